// File: sv/wdfg_pkg.sv
package wdfg_pkg;

    // Table and fixed-point settings
    localparam int SINE_TABLE_DEPTH   = 900;
    localparam int COEF_FRACTION_BITS = 12;
    localparam int TRIG_FRAC_BITS     = 14;
    localparam int TENTHS_QUARTER     = 900;
    localparam int TENTHS_FULL        = 3600;
    localparam int ONE_Q14            = 16384;
    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

    // Field widths
    localparam int SPEED_W   = 16;
    localparam int DIR_W     = 12;
    localparam int COEF_W    = 16;
    localparam int CFG_W     = 32;
    localparam int CFG_IDX_W = 3;
    localparam int HARM_N    = 4;
    localparam int THETA_W   = DIR_W;

    // Sine ROM holds one entry per tenth of a degree over a quarter turn
    localparam int ROM_AW = $clog2(TENTHS_QUARTER + 1);
    localparam int ROM_DW = 15;

    // Datapath widths
    localparam int TERM_W    = COEF_W + ROM_DW;
    localparam int PSUM_W    = TERM_W + 2;
    localparam int ACC_W     = PSUM_W + 2;
    localparam int GAIN_W    = ACC_W - 1;
    localparam int GAIN_LO_W = GAIN_W / 2;
    localparam int GAIN_HI_W = GAIN_W - GAIN_LO_W;
    localparam int SCALE_W   = SPEED_W + GAIN_W + 1;
    localparam int SCALE_SH  = COEF_FRACTION_BITS + TRIG_FRAC_BITS;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_CONSTANT_TERM  = 3'd0,
        CFG_HARMONIC_ONE   = 3'd1,
        CFG_HARMONIC_TWO   = 3'd2,
        CFG_HARMONIC_THREE = 3'd3,
        CFG_HARMONIC_FOUR  = 3'd4
    } t_cfg_index;

    typedef logic [THETA_W-1:0] t_theta;
    typedef logic [ROM_AW-1:0]  t_rom_addr;
    typedef logic [ROM_DW-1:0]  t_rom_data;
    typedef logic [GAIN_W-1:0]  t_gain;

    // Word fields that ride along the pipeline
    typedef struct packed {
        logic [SPEED_W-1:0] speed;
        logic               speed_ok;
        logic               apply;
    } t_item;

    // Sine and cosine lookups for each harmonic
    typedef struct packed {
        t_rom_addr [HARM_N-1:0] sin_addr;
        t_rom_addr [HARM_N-1:0] cos_addr;
        logic      [HARM_N-1:0] sin_neg;
        logic      [HARM_N-1:0] cos_neg;
    } t_trig_req;

    typedef t_rom_data t_sine_rom [0:TENTHS_QUARTER];

    localparam logic [63:0] SERIES_DIV [1:6] =
        '{64'd6, 64'd20, 64'd42, 64'd72, 64'd110, 64'd156};

    // Q14 sine of table point idx: Q30 Taylor series to x^13, truncating steps
    function automatic t_rom_data sine_entry(input logic [63:0] idx);
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] term;
        longint      sum;
        x    = (HALF_PI_Q30 * idx + 64'(SINE_TABLE_DEPTH / 2)) / 64'(SINE_TABLE_DEPTH);
        x2   = (x * x) >> 30;
        term = x;
        sum  = longint'(x);
        for (int n = 1; n <= 6; n++) begin
            term = ((term * x2) >> 30) / SERIES_DIV[n];
            if ((n & 1) != 0) begin
                sum = sum - longint'(term);
            end else begin
                sum = sum + longint'(term);
            end
        end
        if (sum < 0) begin
            sum = 0;
        end
        sum = (sum + 32768) >>> 16;
        if (sum > ONE_Q14) begin
            sum = ONE_Q14;
        end
        return ROM_DW'(sum);
    endfunction

    // ROM indexed by remainder in tenths, table index mapping folded in
    function automatic t_sine_rom build_sine_rom();
        t_sine_rom   tab;
        logic [63:0] idx;
        for (int r = 0; r <= TENTHS_QUARTER; r++) begin
            idx = (64'(r) * 64'(SINE_TABLE_DEPTH) + 64'(TENTHS_QUARTER / 2))
                  / 64'(TENTHS_QUARTER);
            if (idx > 64'(SINE_TABLE_DEPTH)) begin
                idx = 64'(SINE_TABLE_DEPTH);
            end
            tab[r] = sine_entry(idx);
        end
        return tab;
    endfunction

    localparam t_sine_rom SINE_ROM = build_sine_rom();

endpackage

// File: sv/wdfg_angle.sv
module wdfg_angle (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_vld,
    output logic                          o_rdy,
    input  wdfg_pkg::t_item               i_item,
    input  logic [wdfg_pkg::DIR_W-1:0]    i_dir,
    output logic                          o_vld,
    input  logic                          i_rdy,
    output wdfg_pkg::t_item               o_item,
    output wdfg_pkg::t_trig_req           o_req
);
    import wdfg_pkg::*;

    // Fold an angle below four full turns back into one turn
    function automatic t_theta reduce_turn(input logic [THETA_W+1:0] v);
        logic [THETA_W+1:0] q;
        if (v >= (THETA_W+2)'(3 * TENTHS_FULL)) begin
            q = v - (THETA_W+2)'(3 * TENTHS_FULL);
        end else if (v >= (THETA_W+2)'(2 * TENTHS_FULL)) begin
            q = v - (THETA_W+2)'(2 * TENTHS_FULL);
        end else if (v >= (THETA_W+2)'(TENTHS_FULL)) begin
            q = v - (THETA_W+2)'(TENTHS_FULL);
        end else begin
            q = v;
        end
        return THETA_W'(q);
    endfunction

    logic [2:0]       r_vld;
    logic [2:0]       en;
    t_item            r_item1, r_item2, r_item3;
    t_theta           r_dir1;
    t_theta           n_dir1;
    t_theta           r_theta2 [HARM_N];
    t_theta           n_theta2 [HARM_N];
    t_trig_req        r_req3;
    t_trig_req        n_req3;
    logic [1:0]       quad   [HARM_N];
    logic [1:0]       quad_c [HARM_N];
    t_rom_addr        rem    [HARM_N];

    // Advance a stage when it is empty or its successor advances
    assign en[2] = ~r_vld[2] | i_rdy;
    assign en[1] = ~r_vld[1] | en[2];
    assign en[0] = ~r_vld[0] | en[1];
    assign o_rdy = en[0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (en[0]) r_vld[0] <= i_vld;
            if (en[1]) r_vld[1] <= r_vld[0];
            if (en[2]) r_vld[2] <= r_vld[1];
        end
    end

    // Reduce the raw direction into one turn
    always_comb begin
        if (i_dir >= DIR_W'(TENTHS_FULL)) begin
            n_dir1 = i_dir - DIR_W'(TENTHS_FULL);
        end else begin
            n_dir1 = i_dir;
        end
    end

    // Harmonic angles k times direction, one turn wrap
    always_comb begin
        for (int k = 0; k < HARM_N; k++) begin
            n_theta2[k] = reduce_turn((THETA_W+2)'(r_dir1) * (THETA_W+2)'(k + 1));
        end
    end

    // Split into quadrant and remainder, mirror odd quadrants
    always_comb begin
        n_req3 = '0;
        for (int k = 0; k < HARM_N; k++) begin
            if (r_theta2[k] >= THETA_W'(3 * TENTHS_QUARTER)) begin
                quad[k] = 2'd3;
                rem[k]  = ROM_AW'(r_theta2[k] - THETA_W'(3 * TENTHS_QUARTER));
            end else if (r_theta2[k] >= THETA_W'(2 * TENTHS_QUARTER)) begin
                quad[k] = 2'd2;
                rem[k]  = ROM_AW'(r_theta2[k] - THETA_W'(2 * TENTHS_QUARTER));
            end else if (r_theta2[k] >= THETA_W'(TENTHS_QUARTER)) begin
                quad[k] = 2'd1;
                rem[k]  = ROM_AW'(r_theta2[k] - THETA_W'(TENTHS_QUARTER));
            end else begin
                quad[k] = 2'd0;
                rem[k]  = ROM_AW'(r_theta2[k]);
            end
            // cosine is the sine one quadrant ahead
            quad_c[k] = quad[k] + 2'd1;
            n_req3.sin_addr[k] = quad[k][0] ? ROM_AW'(TENTHS_QUARTER) - rem[k] : rem[k];
            n_req3.cos_addr[k] = quad_c[k][0] ? ROM_AW'(TENTHS_QUARTER) - rem[k] : rem[k];
            n_req3.sin_neg[k]  = quad[k][1];
            n_req3.cos_neg[k]  = quad_c[k][1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en[0]) begin
            r_item1 <= i_item;
            r_dir1  <= n_dir1;
        end
        if (en[1]) begin
            r_item2 <= r_item1;
            r_theta2 <= n_theta2;
        end
        if (en[2]) begin
            r_item3 <= r_item2;
            r_req3  <= n_req3;
        end
    end

    assign o_vld  = r_vld[2];
    assign o_item = r_item3;
    assign o_req  = r_req3;

endmodule

// File: sv/wdfg_sine_rom.sv
module wdfg_sine_rom (
    input  logic                 i_clk,
    input  logic                 i_en,
    input  wdfg_pkg::t_rom_addr  i_addr_a,
    input  wdfg_pkg::t_rom_addr  i_addr_b,
    output wdfg_pkg::t_rom_data  o_data_a,
    output wdfg_pkg::t_rom_data  o_data_b
);
    import wdfg_pkg::*;

    t_rom_data r_data_a;
    t_rom_data r_data_b;

    // Two registered read ports on the quarter-wave table
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_data_a <= SINE_ROM[i_addr_a];
            r_data_b <= SINE_ROM[i_addr_b];
        end
    end

    assign o_data_a = r_data_a;
    assign o_data_b = r_data_b;

endmodule

// File: sv/wdfg_gain.sv
module wdfg_gain (
    input  logic                                        i_clk,
    input  logic                                        i_rst_n,
    input  logic                                        i_vld,
    output logic                                        o_rdy,
    input  wdfg_pkg::t_item                             i_item,
    input  wdfg_pkg::t_trig_req                         i_req,
    input  logic [wdfg_pkg::COEF_W-1:0]                 i_const_term,
    input  logic [wdfg_pkg::HARM_N-1:0][wdfg_pkg::CFG_W-1:0] i_harm,
    output logic                                        o_vld,
    input  logic                                        i_rdy,
    output wdfg_pkg::t_item                             o_item,
    output wdfg_pkg::t_gain                             o_gain
);
    import wdfg_pkg::*;

    localparam int TERM_N = 2 * HARM_N;
    localparam int PROD_W = COEF_W + ROM_DW + 2;

    logic [3:0]                  r_vld;
    logic [3:0]                  en;
    t_item                       r_item4, r_item5, r_item6, r_item7;
    logic [HARM_N-1:0]           r_sin_neg4;
    logic [HARM_N-1:0]           r_cos_neg4;
    t_rom_data                   rom_sin [HARM_N];
    t_rom_data                   rom_cos [HARM_N];
    logic signed [COEF_W:0]      coef_adj [TERM_N];
    logic signed [PROD_W-1:0]    prod [TERM_N];
    logic signed [TERM_W-1:0]    n_term5 [TERM_N];
    logic signed [TERM_W-1:0]    r_term5 [TERM_N];
    logic signed [TERM_W-1:0]    n_base5;
    logic signed [TERM_W-1:0]    r_base5;
    logic signed [PSUM_W-1:0]    n_psum6 [3];
    logic signed [PSUM_W-1:0]    r_psum6 [3];
    logic signed [ACC_W-1:0]     acc;
    t_gain                       n_gain7;
    t_gain                       r_gain7;

    assign en[3] = ~r_vld[3] | i_rdy;
    assign en[2] = ~r_vld[2] | en[3];
    assign en[1] = ~r_vld[1] | en[2];
    assign en[0] = ~r_vld[0] | en[1];
    assign o_rdy = en[0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (en[0]) r_vld[0] <= i_vld;
            if (en[1]) r_vld[1] <= r_vld[0];
            if (en[2]) r_vld[2] <= r_vld[1];
            if (en[3]) r_vld[3] <= r_vld[2];
        end
    end

    // Table lookups: one ROM per harmonic, sine and cosine ports
    for (genvar k = 0; k < HARM_N; k++) begin : g_rom
        wdfg_sine_rom u_rom (
            .i_clk    (i_clk),
            .i_en     (en[0]),
            .i_addr_a (i_req.sin_addr[k]),
            .i_addr_b (i_req.cos_addr[k]),
            .o_data_a (rom_sin[k]),
            .o_data_b (rom_cos[k])
        );
    end

    // Apply quadrant sign to the coefficient, then multiply by the table value
    always_comb begin
        for (int k = 0; k < HARM_N; k++) begin
            coef_adj[2*k] = {i_harm[k][CFG_W-1], i_harm[k][CFG_W-1:COEF_W]};
            coef_adj[2*k+1] = {i_harm[k][COEF_W-1], i_harm[k][COEF_W-1:0]};
            if (r_sin_neg4[k]) coef_adj[2*k] = -coef_adj[2*k];
            if (r_cos_neg4[k]) coef_adj[2*k+1] = -coef_adj[2*k+1];
            prod[2*k]   = PROD_W'(coef_adj[2*k])
                          * PROD_W'($signed({1'b0, rom_sin[k]}));
            prod[2*k+1] = PROD_W'(coef_adj[2*k+1])
                          * PROD_W'($signed({1'b0, rom_cos[k]}));
        end
        for (int j = 0; j < TERM_N; j++) begin
            n_term5[j] = prod[j][TERM_W-1:0];
        end
        n_base5 = {{(TERM_W-COEF_W-TRIG_FRAC_BITS){i_const_term[COEF_W-1]}},
                   i_const_term, {TRIG_FRAC_BITS{1'b0}}};
    end

    // First adder level: three groups of three
    always_comb begin
        n_psum6[0] = PSUM_W'(r_term5[0]) + PSUM_W'(r_term5[1]) + PSUM_W'(r_term5[2]);
        n_psum6[1] = PSUM_W'(r_term5[3]) + PSUM_W'(r_term5[4]) + PSUM_W'(r_term5[5]);
        n_psum6[2] = PSUM_W'(r_term5[6]) + PSUM_W'(r_term5[7]) + PSUM_W'(r_base5);
    end

    // Final sum, clamp negative gain to zero
    always_comb begin
        acc = ACC_W'(r_psum6[0]) + ACC_W'(r_psum6[1]) + ACC_W'(r_psum6[2]);
        if (acc[ACC_W-1]) begin
            n_gain7 = '0;
        end else begin
            n_gain7 = acc[GAIN_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en[0]) begin
            r_item4    <= i_item;
            r_sin_neg4 <= i_req.sin_neg;
            r_cos_neg4 <= i_req.cos_neg;
        end
        if (en[1]) begin
            r_item5 <= r_item4;
            r_term5 <= n_term5;
            r_base5 <= n_base5;
        end
        if (en[2]) begin
            r_item6 <= r_item5;
            r_psum6 <= n_psum6;
        end
        if (en[3]) begin
            r_item7 <= r_item6;
            r_gain7 <= n_gain7;
        end
    end

    assign o_vld  = r_vld[3];
    assign o_item = r_item7;
    assign o_gain = r_gain7;

endmodule

// File: sv/wdfg_scale.sv
module wdfg_scale (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_vld,
    output logic                          o_rdy,
    input  wdfg_pkg::t_item               i_item,
    input  wdfg_pkg::t_gain               i_gain,
    output logic                          o_vld,
    input  logic                          i_rdy,
    output logic [wdfg_pkg::SPEED_W-1:0]  o_speed,
    output logic                          o_speed_ok,
    output logic                          o_applied
);
    import wdfg_pkg::*;

    localparam int SHIFTED_W = SCALE_W - SCALE_SH;
    localparam int PLO_W     = SPEED_W + GAIN_LO_W;
    localparam int PHI_W     = SPEED_W + GAIN_HI_W;

    logic [1:0]                          r_vld;
    logic [1:0]                          en;
    t_item                               r_item8;
    logic [PLO_W-1:0]                    r_plo8;
    logic [PHI_W-1:0]                    r_phi8;
    logic [SCALE_W-1:0]                  full;
    logic [SHIFTED_W-1:0]                shifted;
    logic [SPEED_W-1:0]                  n_speed9;
    logic [SPEED_W-1:0]                  r_speed9;
    logic                                r_speed_ok9;
    logic                                r_applied9;

    assign en[1] = ~r_vld[1] | i_rdy;
    assign en[0] = ~r_vld[0] | en[1];
    assign o_rdy = en[0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (en[0]) r_vld[0] <= i_vld;
            if (en[1]) r_vld[1] <= r_vld[0];
        end
    end

    // Recombine partial products, round half up, saturate, bypass
    always_comb begin
        full = SCALE_W'({r_phi8, {GAIN_LO_W{1'b0}}}) + SCALE_W'(r_plo8)
               + (SCALE_W'(1) << (SCALE_SH - 1));
        shifted = full[SCALE_W-1:SCALE_SH];
        if (!r_item8.apply) begin
            n_speed9 = r_item8.speed;
        end else if (|shifted[SHIFTED_W-1:SPEED_W]) begin
            n_speed9 = '1;
        end else begin
            n_speed9 = shifted[SPEED_W-1:0];
        end
    end

    // Speed times gain split in two narrow halves
    always_ff @(posedge i_clk) begin
        if (en[0]) begin
            r_item8 <= i_item;
            r_plo8  <= PLO_W'(i_item.speed) * PLO_W'(i_gain[GAIN_LO_W-1:0]);
            r_phi8  <= PHI_W'(i_item.speed) * PHI_W'(i_gain[GAIN_W-1:GAIN_LO_W]);
        end
        if (en[1]) begin
            r_speed9    <= n_speed9;
            r_speed_ok9 <= r_item8.speed_ok;
            r_applied9  <= r_item8.apply;
        end
    end

    assign o_vld      = r_vld[1];
    assign o_speed    = r_speed9;
    assign o_speed_ok = r_speed_ok9;
    assign o_applied  = r_applied9;

endmodule

// File: sv/wind_direction_fourier_gain_top.sv
// Channel   Handshake              Word
// in        i_valid / o_ready      i_wind_speed, i_speed_valid, i_direction_tenths,
//                                  i_direction_valid
// out       o_valid / i_ready      o_corrected_speed, o_corrected_valid, o_gain_applied
// config    i_cfg_we               i_cfg_index, i_cfg_data (write only)
//
// One word per cycle sustained while i_ready is high; each word passes through the
// register stage chain: angle fold, harmonic angle wrap, quadrant split,
// sine ROM read, coefficient multiply, two adder levels, split speed multiply,
// round and saturate.
// Reset clears all stage valid bits and loads the coefficient reset values.
// A stalled output holds only the stages that are full; empty stages keep filling.
module wind_direction_fourier_gain_top (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_valid,
    output logic                             o_ready,
    input  logic [wdfg_pkg::SPEED_W-1:0]     i_wind_speed,
    input  logic                             i_speed_valid,
    input  logic [wdfg_pkg::DIR_W-1:0]       i_direction_tenths,
    input  logic                             i_direction_valid,
    output logic                             o_valid,
    input  logic                             i_ready,
    output logic [wdfg_pkg::SPEED_W-1:0]     o_corrected_speed,
    output logic                             o_corrected_valid,
    output logic                             o_gain_applied,
    input  logic                             i_cfg_we,
    input  logic [wdfg_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [wdfg_pkg::CFG_W-1:0]       i_cfg_data
);
    import wdfg_pkg::*;

    logic [COEF_W-1:0]             r_const_term;
    logic [HARM_N-1:0][CFG_W-1:0]  r_harm;
    t_item                         in_item;
    t_item                         ang_item;
    t_item                         gain_item;
    t_trig_req                     ang_req;
    t_gain                         gain_val;
    logic                          ang_vld, ang_rdy;
    logic                          gain_vld, gain_rdy;

    // Coefficient registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_const_term <= COEF_W'(4096);
            r_harm       <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_CONSTANT_TERM:  r_const_term <= i_cfg_data[COEF_W-1:0];
                CFG_HARMONIC_ONE:   r_harm[0]    <= i_cfg_data;
                CFG_HARMONIC_TWO:   r_harm[1]    <= i_cfg_data;
                CFG_HARMONIC_THREE: r_harm[2]    <= i_cfg_data;
                CFG_HARMONIC_FOUR:  r_harm[3]    <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Gain applies only when both flags are set
    assign in_item.speed    = i_wind_speed;
    assign in_item.speed_ok = i_speed_valid;
    assign in_item.apply    = i_speed_valid & i_direction_valid;

    wdfg_angle u_angle (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_vld    (i_valid),
        .o_rdy    (o_ready),
        .i_item   (in_item),
        .i_dir    (i_direction_tenths),
        .o_vld    (ang_vld),
        .i_rdy    (ang_rdy),
        .o_item   (ang_item),
        .o_req    (ang_req)
    );

    wdfg_gain u_gain (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_vld        (ang_vld),
        .o_rdy        (ang_rdy),
        .i_item       (ang_item),
        .i_req        (ang_req),
        .i_const_term (r_const_term),
        .i_harm       (r_harm),
        .o_vld        (gain_vld),
        .i_rdy        (gain_rdy),
        .o_item       (gain_item),
        .o_gain       (gain_val)
    );

    wdfg_scale u_scale (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_vld      (gain_vld),
        .o_rdy      (gain_rdy),
        .i_item     (gain_item),
        .i_gain     (gain_val),
        .o_vld      (o_valid),
        .i_rdy      (i_ready),
        .o_speed    (o_corrected_speed),
        .o_speed_ok (o_corrected_valid),
        .o_applied  (o_gain_applied)
    );

endmodule

// File: test/wdfg_gain_checker.sv
`timescale 1ns / 1ps

module wdfg_gain_checker (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    input  logic                           i_in_ready,
    input  logic [wdfg_pkg::SPEED_W-1:0]   i_wind_speed,
    input  logic                           i_speed_valid,
    input  logic [wdfg_pkg::DIR_W-1:0]     i_direction_tenths,
    input  logic                           i_direction_valid,
    input  logic                           i_out_valid,
    input  logic                           i_out_ready,
    input  logic [wdfg_pkg::SPEED_W-1:0]   i_corrected_speed,
    input  logic                           i_corrected_valid,
    input  logic                           i_gain_applied,
    input  logic                           i_cfg_we,
    input  logic [wdfg_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [wdfg_pkg::CFG_W-1:0]     i_cfg_data,
    output int                             o_pending,
    output int                             o_fail_count
);

    localparam int          POINTS      = 900;
    localparam int          QUARTER     = 900;
    localparam int          FULL_TURN   = 3600;
    localparam longint      UNIT_Q14    = 16384;
    localparam int          GAIN_SHIFT  = 26;
    localparam logic [63:0] QUARTER_Q30 = 64'd1686629713;

    typedef struct packed {
        logic [15:0] speed;
        logic        valid;
        logic        applied;
    } t_corrected;

    logic [14:0]        quarter_sine [0:POINTS];
    logic signed [15:0] coef_a;
    logic [31:0]        harm [0:3];
    t_corrected         corrected_q [$];
    int                 fail_total = 0;

    // Q14 sine of quarter-wave point i, Q30 series with truncating steps
    function automatic logic [14:0] sine_point(int unsigned i);
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] term;
        longint      total;
        x     = (QUARTER_Q30 * 64'(i) + 64'(POINTS / 2)) / 64'(POINTS);
        x2    = (x * x) >> 30;
        term  = x;
        total = longint'(x);
        for (int n = 1; n <= 6; n++) begin
            term = ((term * x2) >> 30) / 64'((2 * n) * (2 * n + 1));
            if (n % 2 == 1) begin
                total = total - longint'(term);
            end else begin
                total = total + longint'(term);
            end
        end
        if (total < 0) begin
            total = 0;
        end
        total = (total + 32768) >>> 16;
        if (total > UNIT_Q14) begin
            total = UNIT_Q14;
        end
        return 15'(total);
    endfunction

    // Signed Q14 sine of an angle in tenths, folded onto the quarter wave
    function automatic longint trig_q14(int unsigned theta);
        int unsigned t;
        int unsigned quad;
        int unsigned rem;
        int unsigned off;
        int unsigned idx;
        longint      v;
        t    = theta % FULL_TURN;
        quad = t / QUARTER;
        rem  = t % QUARTER;
        off  = (quad % 2 == 1) ? QUARTER - rem : rem;
        idx  = (off * POINTS + QUARTER / 2) / QUARTER;
        if (idx > POINTS) begin
            idx = POINTS;
        end
        v = longint'(quarter_sine[idx]);
        return (quad >= 2) ? -v : v;
    endfunction

    // Corrected speed word for one input word under the current coefficients
    function automatic t_corrected predict_corrected(logic [15:0] spd, logic spd_ok,
                                                     logic [11:0] dir_raw, logic dir_ok);
        t_corrected         r;
        longint             acc;
        int unsigned        dir;
        int unsigned        theta;
        logic signed [15:0] sin_c;
        logic signed [15:0] cos_c;
        logic [63:0]        prod;
        r.speed   = spd;
        r.valid   = spd_ok;
        r.applied = 1'b0;
        if (spd_ok && dir_ok) begin
            dir = int'(dir_raw) % FULL_TURN;
            acc = longint'(coef_a) * UNIT_Q14;
            for (int k = 1; k <= 4; k++) begin
                theta = (k * dir) % FULL_TURN;
                sin_c = harm[k-1][31:16];
                cos_c = harm[k-1][15:0];
                acc   = acc + longint'(sin_c) * trig_q14(theta);
                acc   = acc + longint'(cos_c) * trig_q14(theta + QUARTER);
            end
            if (acc < 0) begin
                acc = 0;
            end
            prod      = (64'(spd) * 64'(acc) + (64'd1 << (GAIN_SHIFT - 1))) >> GAIN_SHIFT;
            r.speed   = (prod > 64'd65535) ? 16'hFFFF : prod[15:0];
            r.applied = 1'b1;
        end
        return r;
    endfunction

    initial begin
        for (int i = 0; i <= POINTS; i++) begin
            quarter_sine[i] = sine_point(i);
        end
    end

    // Check results, queue predictions, mirror register writes
    always @(posedge i_clk) begin
        t_corrected want;
        if (!i_rst_n) begin
            coef_a = 16'sd4096;
            for (int k = 0; k < 4; k++) begin
                harm[k] = '0;
            end
            corrected_q.delete();
        end else begin
            if (i_out_valid && i_out_ready) begin
                if (corrected_q.size() == 0) begin
                    $display("%0t: unexpected word: expected none, actual speed %0d valid %0b applied %0b",
                             $time, i_corrected_speed, i_corrected_valid, i_gain_applied);
                    fail_total++;
                end else begin
                    want = corrected_q.pop_front();
                    if (i_corrected_speed !== want.speed) begin
                        $display("%0t: corrected_speed mismatch: expected %0d actual %0d",
                                 $time, want.speed, i_corrected_speed);
                        fail_total++;
                    end
                    if (i_corrected_valid !== want.valid) begin
                        $display("%0t: corrected_valid mismatch: expected %0b actual %0b",
                                 $time, want.valid, i_corrected_valid);
                        fail_total++;
                    end
                    if (i_gain_applied !== want.applied) begin
                        $display("%0t: gain_applied mismatch: expected %0b actual %0b",
                                 $time, want.applied, i_gain_applied);
                        fail_total++;
                    end
                end
            end
            if (i_in_valid && i_in_ready) begin
                corrected_q.push_back(predict_corrected(i_wind_speed, i_speed_valid,
                                                        i_direction_tenths, i_direction_valid));
            end
            if (i_cfg_we) begin
                case (i_cfg_index)
                    wdfg_pkg::CFG_CONSTANT_TERM:  coef_a  = i_cfg_data[15:0];
                    wdfg_pkg::CFG_HARMONIC_ONE:   harm[0] = i_cfg_data;
                    wdfg_pkg::CFG_HARMONIC_TWO:   harm[1] = i_cfg_data;
                    wdfg_pkg::CFG_HARMONIC_THREE: harm[2] = i_cfg_data;
                    wdfg_pkg::CFG_HARMONIC_FOUR:  harm[3] = i_cfg_data;
                    default: ;
                endcase
            end
        end
        o_pending    <= corrected_q.size();
        o_fail_count <= fail_total;
    end

endmodule

// File: test/wind_direction_fourier_gain_top_tb.sv
`timescale 1ns / 1ps

module wind_direction_fourier_gain_top_tb;

    logic                           i_clk;
    logic                           i_rst_n;
    logic                           i_valid;
    logic                           o_ready;
    logic [wdfg_pkg::SPEED_W-1:0]   i_wind_speed;
    logic                           i_speed_valid;
    logic [wdfg_pkg::DIR_W-1:0]     i_direction_tenths;
    logic                           i_direction_valid;
    logic                           o_valid;
    logic                           i_ready;
    logic [wdfg_pkg::SPEED_W-1:0]   o_corrected_speed;
    logic                           o_corrected_valid;
    logic                           o_gain_applied;
    logic                           i_cfg_we;
    logic [wdfg_pkg::CFG_IDX_W-1:0] i_cfg_index;
    logic [wdfg_pkg::CFG_W-1:0]     i_cfg_data;

    int pending;
    int fail_count;
    bit calm;

    localparam int PHASES          = 8;
    localparam int WORDS_PER_PHASE = 166;

    wind_direction_fourier_gain_top dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_valid           (i_valid),
        .o_ready           (o_ready),
        .i_wind_speed      (i_wind_speed),
        .i_speed_valid     (i_speed_valid),
        .i_direction_tenths(i_direction_tenths),
        .i_direction_valid (i_direction_valid),
        .o_valid           (o_valid),
        .i_ready           (i_ready),
        .o_corrected_speed (o_corrected_speed),
        .o_corrected_valid (o_corrected_valid),
        .o_gain_applied    (o_gain_applied),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_index       (i_cfg_index),
        .i_cfg_data        (i_cfg_data)
    );

    wdfg_gain_checker u_gain_check (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_in_valid        (i_valid),
        .i_in_ready        (o_ready),
        .i_wind_speed      (i_wind_speed),
        .i_speed_valid     (i_speed_valid),
        .i_direction_tenths(i_direction_tenths),
        .i_direction_valid (i_direction_valid),
        .i_out_valid       (o_valid),
        .i_out_ready       (i_ready),
        .i_corrected_speed (o_corrected_speed),
        .i_corrected_valid (o_corrected_valid),
        .i_gain_applied    (o_gain_applied),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_index       (i_cfg_index),
        .i_cfg_data        (i_cfg_data),
        .o_pending         (pending),
        .o_fail_count      (fail_count)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #3_000_000;
        $display("wind_direction_fourier_gain_top_tb NOT OK");
        $finish;
    end

    // Stall the result side in random bursts, none once calm
    initial begin
        i_ready <= 1'b0;
        @(posedge i_clk);
        forever begin
            if (!calm && $urandom_range(0, 3) == 0) begin
                i_ready <= 1'b0;
                repeat ($urandom_range(1, 14)) @(posedge i_clk);
            end
            i_ready <= 1'b1;
            repeat ($urandom_range(1, 24)) @(posedge i_clk);
        end
    end

    // Present one word and hold it until accepted
    task automatic send_word(input logic [15:0] spd, input logic spd_ok,
                             input logic [11:0] dir, input logic dir_ok);
        i_valid            <= 1'b1;
        i_wind_speed       <= spd;
        i_speed_valid      <= spd_ok;
        i_direction_tenths <= dir;
        i_direction_valid  <= dir_ok;
        do @(posedge i_clk); while (!o_ready);
    endtask

    // Drop valid, wait for every expected word, then let the pipeline empty
    task automatic settle();
        i_valid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
        repeat (12) @(posedge i_clk);
    endtask

    task automatic put_reg(input wdfg_pkg::t_cfg_index idx, input logic [31:0] data);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
    endtask

    task automatic load_coefs(input logic [31:0] a_word, input logic [31:0] h1,
                              input logic [31:0] h2, input logic [31:0] h3,
                              input logic [31:0] h4);
        put_reg(wdfg_pkg::CFG_CONSTANT_TERM, a_word);
        put_reg(wdfg_pkg::CFG_HARMONIC_ONE, h1);
        put_reg(wdfg_pkg::CFG_HARMONIC_TWO, h2);
        put_reg(wdfg_pkg::CFG_HARMONIC_THREE, h3);
        put_reg(wdfg_pkg::CFG_HARMONIC_FOUR, h4);
        i_cfg_we <= 1'b0;
    endtask

    // Small signed coefficient in -span..span
    function automatic logic [15:0] near(int span);
        return 16'(int'($urandom_range(0, 2 * span)) - span);
    endfunction

    function automatic logic [31:0] mild_pair();
        return {near(700), near(700)};
    endfunction

    initial begin
        logic [11:0] sweep [0:8];
        logic [15:0] spd;
        logic [11:0] dir;
        sweep = '{12'd0, 12'd450, 12'd900, 12'd1350, 12'd1800, 12'd2250, 12'd2700,
                  12'd3150, 12'd3599};
        calm               = 1'b0;
        i_rst_n            <= 1'b0;
        i_valid            <= 1'b0;
        i_wind_speed       <= '0;
        i_speed_valid      <= 1'b0;
        i_direction_tenths <= '0;
        i_direction_valid  <= 1'b0;
        i_cfg_we           <= 1'b0;
        i_cfg_index        <= wdfg_pkg::CFG_CONSTANT_TERM;
        i_cfg_data         <= '0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset coefficients give unity gain; flags and wrapped directions
        send_word(16'd0, 1'b1, 12'd0, 1'b1);
        send_word(16'hFFFF, 1'b1, 12'd900, 1'b1);
        send_word(16'd12345, 1'b0, 12'd1800, 1'b1);
        send_word(16'd23456, 1'b1, 12'd2700, 1'b0);
        send_word(16'hFFFF, 1'b0, 12'hFFF, 1'b0);
        send_word(16'd777, 1'b1, 12'd3600, 1'b1);
        send_word(16'd4242, 1'b1, 12'hFFF, 1'b1);
        settle();

        // Sweep quadrant points with mixed harmonic signs
        load_coefs({16'hA5A5, 16'd4096}, 32'h0800_0400, 32'hFC00_0200,
                   32'h0100_FF00, 32'hFF80_0080);
        foreach (sweep[i]) begin
            send_word(16'd10000, 1'b1, sweep[i], 1'b1);
        end
        settle();

        // Negative gain clamps to zero
        load_coefs(32'h0000_8000, 32'h0, 32'h0, 32'h0, 32'h0);
        send_word(16'd30000, 1'b1, 12'd123, 1'b1);
        settle();

        // Large gain saturates
        load_coefs(32'h0000_7FFF, 32'h7FFF_7FFF, 32'h7FFF_7FFF, 32'h7FFF_7FFF, 32'h7FFF_7FFF);
        send_word(16'd40000, 1'b1, 12'd0, 1'b1);
        settle();

        // Random phases, each under its own coefficient set
        for (int p = 0; p < PHASES; p++) begin
            case (p)
                1, 6: load_coefs($urandom, $urandom, $urandom, $urandom, $urandom);
                2: load_coefs(32'h0000_7FFF, 32'h7FFF_7FFF, 32'h7FFF_7FFF,
                              32'h7FFF_7FFF, 32'h7FFF_7FFF);
                4: load_coefs({16'($urandom), 16'h8000}, 32'h8000_8000, 32'h8000_8000,
                              32'h8000_8000, 32'h8000_8000);
                default: load_coefs({16'($urandom), 16'(4096) + near(1024)}, mild_pair(),
                                    mild_pair(), mild_pair(), mild_pair());
            endcase
            calm = (p == PHASES - 1);
            for (int n = 0; n < WORDS_PER_PHASE; n++) begin
                case ($urandom_range(0, 9))
                    0: spd = 16'd0;
                    1: spd = 16'hFFFF;
                    2: spd = 16'($urandom_range(0, 255));
                    default: spd = 16'($urandom_range(0, 65535));
                endcase
                dir = ($urandom_range(0, 7) == 0) ? 12'($urandom_range(3600, 4095))
                                                  : 12'($urandom_range(0, 3599));
                send_word(spd, $urandom_range(0, 9) != 0, dir, $urandom_range(0, 9) != 0);
                // Hold off the sender in random bursts
                if (!calm && $urandom_range(0, 4) == 0) begin
                    i_valid <= 1'b0;
                    repeat ($urandom_range(1, 14)) @(posedge i_clk);
                end
            end
            settle();
        end

        if (fail_count == 0) begin
            $display("wind_direction_fourier_gain_top_tb OK");
        end else begin
            $display("wind_direction_fourier_gain_top_tb NOT OK");
        end
        $finish;
    end

endmodule
